FILE: rtl/qbpa_pkg.sv
// Shared types and codes of the quaternary buddy page allocator.
// Depends on nothing; imported by the top level and its checker.
package qbpa_pkg;

    localparam int PAGE_COUNT_DEF = 4096;
    localparam int SPLIT_WAYS_DEF = 4;
    localparam int PAGE_W         = 12;
    localparam int ORDERS         = 3;
    localparam int CFG_W          = 7;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOMEM   = 2'd1,
        STS_BADFREE = 2'd2
    } t_status;

    typedef enum logic {
        CFG_FIRST_BLOCK = 1'b0,
        CFG_BLOCK_COUNT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]        action;
        logic [1:0]        order;
        logic [PAGE_W-1:0] page_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [PAGE_W-1:0] granted_page;
    } t_rsp;

    typedef enum logic [5:0] {
        S_CLEAR, S_IDLE, S_IN_START, S_IN_LOOP,
        S_AL_FIND, S_AL_LOOP, S_AL_SPLIT, S_AL_PUSH, S_AL_PNEXT, S_AL_GRANT,
        S_FR_START, S_FR_CHK,
        S_MG_TOP, S_MG_CHK, S_MG_CRD, S_MG_CNEXT, S_MG_UN, S_MG_URD, S_MG_UNEXT,
        S_MG_PUSH,
        S_PU_RD, S_PU_CHK, S_PU_LINK, S_PU_HRD, S_PU_WR,
        S_UN_A, S_UN_PRD, S_UN_B, S_UN_NRD, S_UN_C,
        S_PO_A, S_PO_RD, S_PO_NRD, S_PO_WR,
        S_FIN
    } t_state;

endpackage

FILE: rtl/quad_buddy_page_allocator_unit.sv
// Top level of the quaternary buddy page allocator: sequencer and page table.
// Depends on qbpa_pkg.
//
// Page allocator over PAGE_COUNT 1KB pages in three orders (1KB, 4KB, 16KB),
// each block splitting into four. Every page has one entry in a single page
// table memory holding its next and previous list links, its free-order tag
// and its allocated flag; the three list heads sit in registers. The free
// lists are doubly linked so that a buddy is removed from the middle of a
// list without walking it, while list order stays plain LIFO.
// One request is handled at a time by a sequencer that reads a table entry,
// uses the registered read data in the following cycle and writes it back;
// no two accesses to the table are ever in flight together, so no
// forwarding is needed. An allocate from an empty list splits a larger
// block, twice when a 16KB block must yield a 1KB page, and a free merges
// with its buddies up to twice. Init and reset each sweep the whole table,
// one entry a cycle (PAGE_COUNT entries, 4096 by default), during which no
// beat is accepted; init then pushes each pooled 16KB block onto its free
// list. Configuration writes are taken in every cycle. The result beat sits
// in an output register, so the next request is taken while a result still
// waits.
module quad_buddy_page_allocator_unit
    import qbpa_pkg::*;
#(
    parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_req             i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_rsp             o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam int AW   = $clog2(PAGE_COUNT);
    localparam int LW   = AW + 1;
    localparam int MAXB = PAGE_COUNT / 16;
    localparam logic [LW-1:0] NIL = LW'(PAGE_COUNT);
    localparam logic [AW-1:0] LAST_PAGE = AW'(PAGE_COUNT - 1);

    typedef struct packed {
        logic [LW-1:0] nxt;
        logic [LW-1:0] prv;
        logic [1:0]    tag;
        logic          alloc;
    } t_ent;

    // page table
    t_ent          mem [PAGE_COUNT];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_ent          mem_wd;
    logic [AW-1:0] mem_ra;
    t_ent          r_rd;

    t_state        r_state, n_state;
    logic [LW-1:0] r_head [ORDERS];
    logic [LW-1:0] n_head [ORDERS];
    logic [5:0]    r_first;
    logic [6:0]    r_count;

    logic [1:0]        r_ord, n_ord;
    logic [PAGE_W-1:0] r_pin, n_pin;
    logic [AW-1:0]     r_page, n_page;
    logic [1:0]        r_cur, n_cur;
    logic [1:0]        r_src, n_src;
    logic [1:0]        r_i, n_i;
    logic [6:0]        r_k, n_k;
    logic [AW-1:0]     r_b, n_b;
    logic [AW-1:0]     r_p, n_p;
    logic [1:0]        r_pord, n_pord;
    logic              r_pset, n_pset;
    t_ent              r_w, n_w;
    t_state            r_ret, n_ret;
    t_state            r_uret, n_uret;
    logic [AW-1:0]     r_ci, n_ci;
    logic              r_init, n_init;
    t_status           r_status, n_status;
    logic [PAGE_W-1:0] r_grant, n_grant;
    logic              r_ov, n_ov;
    t_rsp              r_od, n_od;

    function automatic logic [2:0] span_shift(input logic [1:0] ord);
        logic [2:0] s;
        case (ord)
            2'd0:    s = 3'd0;
            2'd1:    s = 3'd2;
            default: s = 3'd4;
        endcase
        return s;
    endfunction

    logic          in_acc;
    logic [6:0]    nblocks;
    logic [10:0]   init_blk;
    logic [AW-1:0] init_pg;
    logic [AW-1:0] al_q;
    logic [2:0]    mg_sh;
    logic [AW-1:0] mg_mask, mg_base, mg_q;
    logic          mg_in_range;
    logic          fr_bad;
    logic          find_ok;
    logic [1:0]    find_src;
    logic [LW-1:0] push_h;
    logic [1:0]    un_ord;

    assign in_acc   = i_in_valid && !o_in_stall;
    // clamp the pool to the blocks the table can hold
    assign nblocks  = (32'(r_count) > MAXB) ? 7'(MAXB) : r_count;
    assign init_blk = {r_k - 7'd1, 4'b0000};
    assign init_pg  = AW'(init_blk);
    assign al_q     = r_b | (AW'(r_i) << span_shift(r_src));
    assign mg_sh    = span_shift(r_cur);
    assign mg_mask  = (AW'(4) << mg_sh) - AW'(1);
    assign mg_base  = r_page & ~mg_mask;
    assign mg_q     = mg_base | (AW'(r_i) << mg_sh);
    assign mg_in_range = ({1'b0, mg_q} < NIL);
    assign push_h   = r_head[r_pord];
    assign un_ord   = r_w.tag - 2'd1;

    // refuse a free that is out of range, of no order, or misaligned
    always_comb begin
        fr_bad = (32'(r_pin) >= PAGE_COUNT) || (r_ord >= 2'(ORDERS));
        if (r_ord == 2'd1 && r_pin[1:0] != 2'd0) fr_bad = 1'b1;
        if (r_ord == 2'd2 && r_pin[3:0] != 4'd0) fr_bad = 1'b1;
    end

    // nearest non-empty list at or above the requested order
    always_comb begin
        find_ok  = 1'b0;
        find_src = 2'd0;
        for (int o = ORDERS - 1; o >= 0; o--) begin
            if (2'(o) >= r_ord && r_head[o] != NIL) begin
                find_ok  = 1'b1;
                find_src = 2'(o);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_ci == LAST_PAGE) n_state = r_init ? S_IN_START : S_IDLE;
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.action)
                        ACT_INIT:  n_state = S_CLEAR;
                        ACT_ALLOC: n_state = S_AL_FIND;
                        ACT_FREE:  n_state = S_FR_START;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_IN_START: n_state = S_IN_LOOP;
            S_IN_LOOP:  n_state = (r_k > {1'b0, r_first}) ? S_PU_RD : S_FIN;
            S_AL_FIND: begin
                if (r_ord >= 2'(ORDERS) || !find_ok) n_state = S_FIN;
                else n_state = S_AL_LOOP;
            end
            S_AL_LOOP:  n_state = S_PO_A;
            S_AL_SPLIT: n_state = S_AL_PUSH;
            S_AL_PUSH:  n_state = S_PU_RD;
            S_AL_PNEXT: n_state = (r_i == 2'd3) ? S_AL_LOOP : S_AL_PUSH;
            S_AL_GRANT: n_state = S_FIN;
            S_FR_START: n_state = fr_bad ? S_FIN : S_FR_CHK;
            S_FR_CHK:   n_state = r_rd.alloc ? S_MG_TOP : S_FIN;
            S_MG_TOP:   n_state = (r_cur == 2'd2) ? S_MG_PUSH : S_MG_CHK;
            S_MG_CHK: begin
                if (mg_q == r_page)    n_state = S_MG_CNEXT;
                else if (!mg_in_range) n_state = S_MG_PUSH;
                else                   n_state = S_MG_CRD;
            end
            S_MG_CRD:   n_state = (r_rd.tag != r_cur + 2'd1) ? S_MG_PUSH : S_MG_CNEXT;
            S_MG_CNEXT: n_state = (r_i == 2'd3) ? S_MG_UN : S_MG_CHK;
            S_MG_UN:    n_state = (mg_q == r_page) ? S_MG_UNEXT : S_MG_URD;
            S_MG_URD:   n_state = S_UN_A;
            S_MG_UNEXT: n_state = (r_i == 2'd3) ? S_MG_TOP : S_MG_UN;
            S_MG_PUSH:  n_state = S_PU_RD;
            S_PU_RD:    n_state = S_PU_CHK;
            S_PU_CHK:   n_state = (r_rd.tag != 2'd0) ? S_UN_A : S_PU_LINK;
            S_PU_LINK:  n_state = (push_h != NIL) ? S_PU_HRD : S_PU_WR;
            S_PU_HRD:   n_state = S_PU_WR;
            S_PU_WR:    n_state = r_ret;
            S_UN_A:     n_state = (r_w.prv == NIL) ? S_UN_B : S_UN_PRD;
            S_UN_PRD:   n_state = S_UN_B;
            S_UN_B:     n_state = (r_w.nxt != NIL) ? S_UN_NRD : S_UN_C;
            S_UN_NRD:   n_state = S_UN_C;
            S_UN_C:     n_state = r_uret;
            S_PO_A:     n_state = S_PO_RD;
            S_PO_RD:    n_state = (r_rd.nxt != NIL) ? S_PO_NRD : S_PO_WR;
            S_PO_NRD:   n_state = S_PO_WR;
            S_PO_WR:    n_state = r_ret;
            S_FIN:      n_state = (!r_ov || !i_out_stall) ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and table access
    always_comb begin
        mem_we   = 1'b0;
        mem_wa   = r_p;
        mem_wd   = r_rd;
        mem_ra   = r_p;
        n_head   = r_head;
        n_ord    = r_ord;
        n_pin    = r_pin;
        n_page   = r_page;
        n_cur    = r_cur;
        n_src    = r_src;
        n_i      = r_i;
        n_k      = r_k;
        n_b      = r_b;
        n_p      = r_p;
        n_pord   = r_pord;
        n_pset   = r_pset;
        n_w      = r_w;
        n_ret    = r_ret;
        n_uret   = r_uret;
        n_ci     = r_ci;
        n_init   = r_init;
        n_status = r_status;
        n_grant  = r_grant;
        n_od     = r_od;
        n_ov     = r_ov && i_out_stall;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_ci;
                mem_wd = '{nxt: NIL, prv: NIL, tag: 2'd0, alloc: 1'b0};
                n_ci   = r_ci + AW'(1);
                if (r_ci == LAST_PAGE) n_init = 1'b0;
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_ord    = i_in_data.order;
                    n_pin    = i_in_data.page_index;
                    n_status = STS_OK;
                    n_grant  = '0;
                    if (i_in_data.action == ACT_INIT) begin
                        n_init = 1'b1;
                        n_ci   = '0;
                        for (int o = 0; o < ORDERS; o++) n_head[o] = NIL;
                    end
                end
            end
            S_IN_START: n_k = nblocks;
            S_IN_LOOP: begin
                if (r_k > {1'b0, r_first}) begin
                    n_p    = init_pg;
                    n_pord = 2'd2;
                    n_ret  = S_IN_LOOP;
                    n_k    = r_k - 7'd1;
                end
            end
            S_AL_FIND: begin
                if (r_ord >= 2'(ORDERS) || !find_ok) n_status = STS_NOMEM;
                else n_src = find_src;
            end
            S_AL_LOOP: begin
                if (r_src > r_ord) begin
                    n_pord = r_src;
                    n_pset = 1'b0;
                    n_ret  = S_AL_SPLIT;
                end else begin
                    n_pord = r_ord;
                    n_pset = 1'b1;
                    n_ret  = S_AL_GRANT;
                end
            end
            S_AL_SPLIT: begin
                n_b   = r_p;
                n_src = r_src - 2'd1;
                n_i   = 2'd0;
            end
            S_AL_PUSH: begin
                // quarters go in address order, so the highest ends on top
                n_p    = al_q;
                n_pord = r_src;
                n_ret  = S_AL_PNEXT;
            end
            S_AL_PNEXT: if (r_i != 2'd3) n_i = r_i + 2'd1;
            S_AL_GRANT: n_grant = PAGE_W'(r_p);
            S_FR_START: begin
                n_page = AW'(r_pin);
                mem_ra = AW'(r_pin);
                if (fr_bad) n_status = STS_BADFREE;
            end
            S_FR_CHK: begin
                if (!r_rd.alloc) begin
                    n_status = STS_BADFREE;
                end else begin
                    mem_we       = 1'b1;
                    mem_wa       = r_page;
                    mem_wd       = r_rd;
                    mem_wd.alloc = 1'b0;
                    n_cur        = r_ord;
                end
            end
            S_MG_TOP: n_i = 2'd0;
            S_MG_CHK: mem_ra = mg_q;
            S_MG_CNEXT: n_i = r_i + 2'd1;
            S_MG_UN: begin
                n_p    = mg_q;
                mem_ra = mg_q;
            end
            S_MG_URD: begin
                n_w    = r_rd;
                n_uret = S_MG_UNEXT;
            end
            S_MG_UNEXT: begin
                n_i = r_i + 2'd1;
                if (r_i == 2'd3) begin
                    n_page = mg_base;
                    n_cur  = r_cur + 2'd1;
                end
            end
            S_MG_PUSH: begin
                n_p    = r_page;
                n_pord = r_cur;
                n_ret  = S_FIN;
            end
            S_PU_RD: mem_ra = r_p;
            S_PU_CHK: begin
                n_w    = r_rd;
                n_uret = S_PU_LINK;
            end
            S_PU_LINK: mem_ra = AW'(push_h);
            S_PU_HRD: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(push_h);
                mem_wd     = r_rd;
                mem_wd.prv = {1'b0, r_p};
            end
            S_PU_WR: begin
                mem_we = 1'b1;
                mem_wa = r_p;
                mem_wd = '{nxt: push_h, prv: NIL, tag: r_pord + 2'd1, alloc: 1'b0};
                n_head[r_pord] = {1'b0, r_p};
            end
            S_UN_A: begin
                if (r_w.prv == NIL) n_head[un_ord] = r_w.nxt;
                mem_ra = AW'(r_w.prv);
            end
            S_UN_PRD: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(r_w.prv);
                mem_wd     = r_rd;
                mem_wd.nxt = r_w.nxt;
            end
            S_UN_B: mem_ra = AW'(r_w.nxt);
            S_UN_NRD: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(r_w.nxt);
                mem_wd     = r_rd;
                mem_wd.prv = r_w.prv;
            end
            S_UN_C: begin
                mem_we = 1'b1;
                mem_wa = r_p;
                mem_wd = '{nxt: NIL, prv: NIL, tag: 2'd0, alloc: r_w.alloc};
            end
            S_PO_A: begin
                n_p    = AW'(push_h);
                mem_ra = AW'(push_h);
            end
            S_PO_RD: begin
                n_w            = r_rd;
                n_head[r_pord] = r_rd.nxt;
                mem_ra         = AW'(r_rd.nxt);
            end
            S_PO_NRD: begin
                mem_we     = 1'b1;
                mem_wa     = AW'(r_w.nxt);
                mem_wd     = r_rd;
                mem_wd.prv = NIL;
            end
            S_PO_WR: begin
                mem_we = 1'b1;
                mem_wa = r_p;
                mem_wd = '{nxt: NIL, prv: NIL, tag: 2'd0, alloc: r_pset | r_w.alloc};
            end
            S_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_ov = 1'b1;
                    n_od = '{status: r_status, granted_page: r_grant};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ci    <= '0;
            r_init  <= 1'b0;
            r_ov    <= 1'b0;
            r_first <= 6'd0;
            r_count <= 7'd64;
            for (int o = 0; o < ORDERS; o++) r_head[o] <= NIL;
        end else begin
            r_state <= n_state;
            r_ci    <= n_ci;
            r_init  <= n_init;
            r_ov    <= n_ov;
            r_head  <= n_head;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_FIRST_BLOCK: r_first <= i_cfg_wdata[5:0];
                    CFG_BLOCK_COUNT: r_count <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ord    <= n_ord;
        r_pin    <= n_pin;
        r_page   <= n_page;
        r_cur    <= n_cur;
        r_src    <= n_src;
        r_i      <= n_i;
        r_k      <= n_k;
        r_b      <= n_b;
        r_p      <= n_p;
        r_pord   <= n_pord;
        r_pset   <= n_pset;
        r_w      <= n_w;
        r_ret    <= n_ret;
        r_uret   <= n_uret;
        r_status <= n_status;
        r_grant  <= n_grant;
        r_od     <= n_od;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

FILE: rtl/qbpa_checker.sv
// Port-level checks for the quaternary buddy page allocator.
// Depends on qbpa_pkg; bound to quad_buddy_page_allocator_unit below.
module qbpa_props
    import qbpa_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_rsp o_out_data
);

    // a result beat that is held back stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // a request beat keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken straight after the first");

    // the table sweep after reset blocks requests
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request taken during the table sweep");

    // a page is only reported with a successful status
    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != STS_OK |-> o_out_data.granted_page == '0)
        else $error("page reported on a failed request");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status != 2'd3)
        else $error("undefined status code");

endmodule

bind quad_buddy_page_allocator_unit qbpa_props u_qbpa_props (.*);
